// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the block's RTL.
// Each macro expects signals named clk and rst in the scope of its use.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an expression at every rising clock edge outside reset.
`define QX_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// Check that a condition leads to a consequence in the next cycle.
`define QX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define QX_ASSERT(label, expr)
`define QX_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/qxmm_pkg.sv -----
// ----------------------------------------------------------------------------
// qxmm_pkg
// Types, codes, constants and saturation helper of the X-frame motor mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qxmm_pkg;

  localparam int unsigned Q_W   = 16;
  localparam int unsigned MIX_W = 28;
  localparam int unsigned DZ_W  = 25;
  localparam int unsigned DXY_W = 24;
  localparam int unsigned DYAW_W = 23;
  localparam int unsigned ADDR_W = 3;

  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_SET    = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_LIN_GAIN = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_YAW_GAIN = 3'd4;

  localparam logic [Q_W-1:0] GAIN_RESET = 16'd256;

  localparam logic signed [MIX_W-1:0] FULL_SCALE = 28'sd25600;
  localparam logic signed [MIX_W-1:0] Q_MAX      = 28'sd32767;
  localparam logic signed [MIX_W-1:0] Q_MIN      = -28'sd32768;

  // Products already shifted down, one sample beat
  typedef struct packed {
    logic [1:0]                func;
    logic signed [DZ_W-1:0]    dz;
    logic signed [DXY_W-1:0]   dx;
    logic signed [DXY_W-1:0]   dy;
    logic signed [DYAW_W-1:0]  dyaw;
    logic signed [Q_W-1:0]     arg;
  } prod_t;

  // Raw mix before range shift
  typedef struct packed {
    logic                      fresh;
    logic signed [Q_W-1:0]     throttle;
    logic signed [MIX_W-1:0]   m0;
    logic signed [MIX_W-1:0]   m1;
    logic signed [MIX_W-1:0]   m2;
    logic signed [MIX_W-1:0]   m3;
  } mix_t;

  typedef struct packed {
    logic                      fresh;
    logic signed [Q_W-1:0]     throttle;
    logic signed [Q_W-1:0]     m0;
    logic signed [Q_W-1:0]     m1;
    logic signed [Q_W-1:0]     m2;
    logic signed [Q_W-1:0]     m3;
  } result_t;

  function automatic logic signed [Q_W-1:0] sat16(input logic signed [MIX_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > Q_MAX) begin
      r = 16'sh7fff;
    end else if (v < Q_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/quad_x_motor_mixer_controller_core.sv -----
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_controller_core
// X-frame quadcopter stabilizer and four-motor mixer, signed Q8.8.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one beat per item. s_tuser carries the function code
//   (sample, add throttle delta, set throttle), s_tdata the velocities, the
//   yaw rate and the throttle argument.
//   Output stream m_*: exactly one beat per input beat, in order. m_tdata
//   carries the four motor commands and the throttle accumulator, m_tuser
//   flags motor fields that a sample computed (zero otherwise).
//   APB port: lin_gain at 0x0, yaw_gain at 0x4; write only while idle.
//   The pipe has three stages (multipliers, accumulator update and mix,
//   range shift), registered in s1, s2 and s3, with the accumulators
//   updated in stage 2; throughput is one beat per cycle while m_tready holds.
//   Each stage loads when it is empty or its successor moves, so a stalled
//   receiver holds the output beat while empty upstream stages keep taking
//   input; the pipe fills and then holds until m_tready returns.
//   Reset clears both accumulators, sets both gains to 1.0 and empties
//   the pipe.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module quad_x_motor_mixer_controller_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // APB configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [qxmm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  // Input stream
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  // meas_vx, meas_vy, meas_vz, goal_vx, goal_vy, goal_vz, yaw_rate, throttle_arg
  input  wire logic [127:0]                s_tdata,
  // func
  input  wire logic [1:0]                  s_tuser,
  // Output stream
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // motor_one, motor_two, motor_three, motor_four, throttle_now
  output logic [79:0]                      m_tdata,
  // motors_fresh
  output logic                             m_tuser
);
  import qxmm_pkg::*;

  logic [Q_W-1:0] lin_gain;
  logic [Q_W-1:0] yaw_gain;
  logic signed [Q_W-1:0] throttle_acc;
  logic signed [Q_W-1:0] yaw_acc;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  prod_t   s1, s1_next;
  mix_t    s2, s2_next;
  result_t s3, s3_next;
  logic signed [Q_W-1:0] throttle_next;
  logic signed [Q_W-1:0] yaw_next;

  logic cfg_wr;

  // ---- configuration ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr)
      ADDR_LIN_GAIN: prdata = {16'd0, lin_gain};
      ADDR_YAW_GAIN: prdata = {16'd0, yaw_gain};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_gain <= GAIN_RESET;
      yaw_gain <= GAIN_RESET;
    end else if (cfg_wr) begin
      if (paddr == ADDR_LIN_GAIN) lin_gain <= pwdata[Q_W-1:0];
      if (paddr == ADDR_YAW_GAIN) yaw_gain <= pwdata[Q_W-1:0];
    end
  end

  // ---- flow control ----
  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  // ---- stage 1: errors and gain products ----
  logic signed [16:0] ex, ey, ez, lgs, ygs;
  logic signed [33:0] px, py, pz;
  logic signed [32:0] pyaw;

  always_comb begin
    ex   = {s_tdata[63:63], s_tdata[63:48]} - {s_tdata[15:15], s_tdata[15:0]};
    ey   = {s_tdata[79:79], s_tdata[79:64]} - {s_tdata[31:31], s_tdata[31:16]};
    ez   = {s_tdata[95:95], s_tdata[95:80]} - {s_tdata[47:47], s_tdata[47:32]};
    lgs  = {1'b0, lin_gain};
    ygs  = {1'b0, yaw_gain};
    px   = ex * lgs;
    py   = ey * lgs;
    pz   = ez * lgs;
    pyaw = $signed(s_tdata[111:96]) * ygs;
    // arithmetic shifts round toward minus infinity
    s1_next.func = s_tuser;
    s1_next.dz   = pz[32:8];
    s1_next.dx   = px[32:9];
    s1_next.dy   = py[32:9];
    s1_next.dyaw = pyaw[31:9];
    s1_next.arg  = $signed(s_tdata[127:112]);
  end

  // ---- stage 2: accumulators and mix ----
  logic signed [17:0] tsum;

  always_comb begin
    throttle_next = throttle_acc;
    yaw_next      = yaw_acc;
    tsum          = 18'(throttle_acc) + 18'(s1.arg);
    s2_next.fresh = 1'b0;
    unique case (s1.func)
      FUNC_SAMPLE: begin
        throttle_next = sat16(MIX_W'(throttle_acc) + MIX_W'(s1.dz));
        yaw_next      = sat16(MIX_W'(yaw_acc) + MIX_W'(s1.dyaw));
        s2_next.fresh = 1'b1;
      end
      FUNC_ADD: begin
        // clamp to 0..100%
        if (MIX_W'(tsum) > FULL_SCALE) begin
          throttle_next = FULL_SCALE[Q_W-1:0];
        end else if (tsum < 18'sd0) begin
          throttle_next = '0;
        end else begin
          throttle_next = tsum[Q_W-1:0];
        end
      end
      FUNC_SET: throttle_next = s1.arg;
      default:  throttle_next = throttle_acc;
    endcase
    s2_next.throttle = throttle_next;
    s2_next.m0 = MIX_W'(throttle_next) + MIX_W'(yaw_next) - MIX_W'(s1.dy) - MIX_W'(s1.dx);
    s2_next.m1 = MIX_W'(throttle_next) - MIX_W'(yaw_next) + MIX_W'(s1.dy) - MIX_W'(s1.dx);
    s2_next.m2 = MIX_W'(throttle_next) + MIX_W'(yaw_next) + MIX_W'(s1.dy) + MIX_W'(s1.dx);
    s2_next.m3 = MIX_W'(throttle_next) - MIX_W'(yaw_next) - MIX_W'(s1.dy) + MIX_W'(s1.dx);
  end

  // ---- stage 3: range shift and saturation ----
  logic signed [MIX_W-1:0] hi, lo, adj;

  always_comb begin
    hi = '0;
    lo = FULL_SCALE;
    if (s2.m0 > hi) hi = s2.m0;
    if (s2.m1 > hi) hi = s2.m1;
    if (s2.m2 > hi) hi = s2.m2;
    if (s2.m3 > hi) hi = s2.m3;
    if (s2.m0 < lo) lo = s2.m0;
    if (s2.m1 < lo) lo = s2.m1;
    if (s2.m2 < lo) lo = s2.m2;
    if (s2.m3 < lo) lo = s2.m3;
    if (hi > FULL_SCALE) begin
      adj = hi - FULL_SCALE;
    end else if (lo < 0) begin
      adj = lo;
    end else begin
      adj = '0;
    end
    s3_next.fresh    = s2.fresh;
    s3_next.throttle = s2.throttle;
    // drop the motor fields for non-sample beats
    s3_next.m0 = s2.fresh ? sat16(s2.m0 - adj) : '0;
    s3_next.m1 = s2.fresh ? sat16(s2.m1 - adj) : '0;
    s3_next.m2 = s2.fresh ? sat16(s2.m2 - adj) : '0;
    s3_next.m3 = s2.fresh ? sat16(s2.m3 - adj) : '0;
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      throttle_acc <= '0;
      yaw_acc      <= '0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      // advance the accumulators once per beat entering stage 2
      if (rdy2 && v1) begin
        throttle_acc <= throttle_next;
        yaw_acc      <= yaw_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && rdy1) s1 <= s1_next;
    if (v1 && rdy2)       s2 <= s2_next;
    if (v2 && rdy3)       s3 <= s3_next;
  end

  assign m_tvalid = v3;
  assign m_tdata  = {s3.throttle, s3.m3, s3.m2, s3.m1, s3.m0};
  assign m_tuser  = s3.fresh;

  // ---- assertions ----
  `QX_ASSERT(a_stale_motors_zero, !(m_tvalid && !m_tuser) || (m_tdata[63:0] == 64'd0))
  `QX_ASSERT(a_ready_when_out_empty, m_tvalid || s_tready)
  `QX_ASSERT_NEXT(a_add_clamped, v1 && rdy2 && (s1.func == FUNC_ADD),
                  (throttle_acc >= 16'sd0) && (MIX_W'(throttle_acc) <= FULL_SCALE))
  `QX_ASSERT_NEXT(a_yaw_hold, !(v1 && rdy2 && (s1.func == FUNC_SAMPLE)), $stable(yaw_acc))

endmodule

`default_nettype wire

// ----- tb/quad_x_motor_mixer_controller_checker.sv -----
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_controller_checker
// Watches the APB port and both streams of the X-frame motor mixer, keeps its
// own throttle and yaw accumulators, works out the motor beat that each input
// beat must produce and compares every output beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quad_x_motor_mixer_controller_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [qxmm_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  input  wire logic                        pready,
  input  wire logic                        s_tvalid,
  input  wire logic                        s_tready,
  // meas_vx, meas_vy, meas_vz, goal_vx, goal_vy, goal_vz, yaw_rate, throttle_arg
  input  wire logic [127:0]                s_tdata,
  // func
  input  wire logic [1:0]                  s_tuser,
  input  wire logic                        m_tvalid,
  input  wire logic                        m_tready,
  // motor_one, motor_two, motor_three, motor_four, throttle_now
  input  wire logic [79:0]                 m_tdata,
  // motors_fresh
  input  wire logic                        m_tuser,
  output int                               mismatches,
  output int                               pending
);
  import qxmm_pkg::*;

  localparam longint PCT_FULL = 25600;
  localparam longint Q_HI     = 32767;
  localparam longint Q_LO     = -32768;

  typedef struct packed {
    logic signed [15:0] motor_one;
    logic signed [15:0] motor_two;
    logic signed [15:0] motor_three;
    logic signed [15:0] motor_four;
    logic signed [15:0] throttle_now;
    logic               motors_fresh;
  } motor_beat_t;

  logic [15:0]        lin_gain;
  logic [15:0]        yaw_gain;
  logic signed [15:0] throttle_acc;
  logic signed [15:0] yaw_acc;
  motor_beat_t        motor_beats_due [$];

  function automatic logic signed [15:0] clamp_q(input longint v);
    if (v > Q_HI) return 16'sh7fff;
    if (v < Q_LO) return 16'sh8000;
    return v[15:0];
  endfunction

  // Advance the accumulators by one item and return the beat it must produce
  function automatic motor_beat_t mix_motor_commands(input logic [1:0] func,
                                                     input logic [127:0] d);
    longint      mvx, mvy, mvz, gvx, gvy, gvz, yaw, arg;
    longint      dx, dy, hi, lo, acc;
    longint      cmd [4];
    motor_beat_t r;
    mvx = $signed(d[15:0]);
    mvy = $signed(d[31:16]);
    mvz = $signed(d[47:32]);
    gvx = $signed(d[63:48]);
    gvy = $signed(d[79:64]);
    gvz = $signed(d[95:80]);
    yaw = $signed(d[111:96]);
    arg = $signed(d[127:112]);
    r = '0;
    case (func)
      FUNC_SAMPLE: begin
        // products are floored: arithmetic shift of a signed value
        acc = longint'(throttle_acc) + (((gvz - mvz) * longint'(lin_gain)) >>> 8);
        throttle_acc = clamp_q(acc);
        dy = ((gvy - mvy) * longint'(lin_gain)) >>> 9;
        dx = ((gvx - mvx) * longint'(lin_gain)) >>> 9;
        acc = longint'(yaw_acc) + ((yaw * longint'(yaw_gain)) >>> 9);
        yaw_acc = clamp_q(acc);
        cmd[0] = longint'(throttle_acc) + longint'(yaw_acc) - dy - dx;
        cmd[1] = longint'(throttle_acc) - longint'(yaw_acc) + dy - dx;
        cmd[2] = longint'(throttle_acc) + longint'(yaw_acc) + dy + dx;
        cmd[3] = longint'(throttle_acc) - longint'(yaw_acc) - dy + dx;
        // bounds search starts from 0 as max and full scale as min
        hi = 0;
        lo = PCT_FULL;
        for (int i = 0; i < 4; i++) begin
          if (cmd[i] > hi) hi = cmd[i];
          if (cmd[i] < lo) lo = cmd[i];
        end
        for (int i = 0; i < 4; i++) begin
          if (hi > PCT_FULL) cmd[i] = cmd[i] - (hi - PCT_FULL);
          else if (lo < 0) cmd[i] = cmd[i] - lo;
        end
        r.motor_one    = clamp_q(cmd[0]);
        r.motor_two    = clamp_q(cmd[1]);
        r.motor_three  = clamp_q(cmd[2]);
        r.motor_four   = clamp_q(cmd[3]);
        r.motors_fresh = 1'b1;
      end
      FUNC_ADD: begin
        acc = longint'(throttle_acc) + arg;
        if (acc > PCT_FULL) acc = PCT_FULL;
        else if (acc < 0) acc = 0;
        throttle_acc = acc[15:0];
      end
      FUNC_SET: begin
        throttle_acc = arg[15:0];
      end
      default: ;
    endcase
    r.throttle_now = throttle_acc;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    motor_beat_t want;
    if (rst) begin
      lin_gain     = GAIN_RESET;
      yaw_gain     = GAIN_RESET;
      throttle_acc = '0;
      yaw_acc      = '0;
      motor_beats_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_LIN_GAIN: lin_gain = pwdata[15:0];
          ADDR_YAW_GAIN: yaw_gain = pwdata[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (motor_beats_due.size() == 0) begin
          $error("output beat with no result expected");
          mismatches++;
        end else begin
          want = motor_beats_due.pop_front();
          check_field("motor_one", want.motor_one, $signed(m_tdata[15:0]));
          check_field("motor_two", want.motor_two, $signed(m_tdata[31:16]));
          check_field("motor_three", want.motor_three, $signed(m_tdata[47:32]));
          check_field("motor_four", want.motor_four, $signed(m_tdata[63:48]));
          check_field("throttle_now", want.throttle_now, $signed(m_tdata[79:64]));
          check_field("motors_fresh", want.motors_fresh, m_tuser);
        end
      end
      if (s_tvalid && s_tready) begin
        motor_beats_due.push_back(mix_motor_commands(s_tuser, s_tdata));
      end
    end
    pending <= motor_beats_due.size();
  end

endmodule

// ----- tb/quad_x_motor_mixer_controller_core_tb.sv -----
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_controller_core_tb
// Drives the X-frame motor mixer with a directed set of sample, throttle add,
// throttle set and unused-code beats, then bursts of random beats under several gain
// settings, with a receiver that stalls in changing patterns. The checker
// beside the block predicts and compares every output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quad_x_motor_mixer_controller_core_tb;
  import qxmm_pkg::*;

  localparam logic [1:0]  FUNC_NOP    = 2'd3;
  localparam logic [15:0] Q_TOP       = 16'h7fff;
  localparam logic [15:0] Q_BOTTOM    = 16'h8000;
  localparam logic [15:0] PCT_HALF    = 16'd12800;
  localparam int          PHASES      = 7;
  localparam int          PHASE_ITEMS = 93;
  localparam int          CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RUNS} rx_mode_e;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [31:0]       pwdata   = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // meas_vx, meas_vy, meas_vz, goal_vx, goal_vy, goal_vz, yaw_rate, throttle_arg
  logic [127:0]      s_tdata  = '0;
  // func
  logic [1:0]        s_tuser  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // motor_one, motor_two, motor_three, motor_four, throttle_now
  logic [79:0]       m_tdata;
  // motors_fresh
  logic              m_tuser;
  int                mismatches;
  int                pending;
  int                cycle_count;

  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_run  = 0;

  quad_x_motor_mixer_controller_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  quad_x_motor_mixer_controller_checker mixer_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: switch between open, coin-flip, sparse and long-run stall patterns
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_run == 0) begin
          m_tready <= !m_tready;
          rx_run   <= $urandom_range(1, 24);
        end else begin
          rx_run <= rx_run - 1;
        end
      end
    endcase
  end

  function automatic logic [127:0] pack_item(input logic [15:0] mvx, mvy, mvz,
                                             gvx, gvy, gvz, yaw, arg);
    return {arg, yaw, gvz, gvy, gvx, mvz, mvy, mvx};
  endfunction

  // Small values most often, some moderate, some full range, zero, -1 and the extremes
  function automatic logic [15:0] rand_q();
    case ($urandom_range(0, 15))
      0:             return Q_TOP;
      1:             return Q_BOTTOM;
      2:             return 16'h0000;
      3:             return 16'hffff;
      4, 5, 6, 7, 8: return 16'($urandom_range(0, 2047) - 1024);
      9, 10, 11:     return 16'($urandom_range(0, 16383) - 8192);
      default:       return 16'($urandom());
    endcase
  endfunction

  task automatic send_item(input logic [1:0] func, input logic [127:0] data);
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int          sent;
    int          burst;
    int          pick;
    logic [1:0]  func;
    logic [15:0] arg;
    logic [15:0] lin;
    logic [15:0] yaw;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the reset gains
    send_item(FUNC_SET, pack_item(0, 0, 0, 0, 0, 0, 0, PCT_HALF));
    send_item(FUNC_SAMPLE, pack_item(0, 0, 0, 0, 0, 0, 0, 0));
    // throttle saturates high, then low
    send_item(FUNC_SAMPLE, pack_item(0, 0, Q_BOTTOM, 0, 0, Q_TOP, 0, 0));
    send_item(FUNC_SAMPLE, pack_item(0, 0, Q_TOP, 0, 0, Q_BOTTOM, 0, 0));
    send_item(FUNC_SAMPLE, pack_item(0, 0, Q_TOP, 0, 0, Q_BOTTOM, 0, 0));
    // add with clamp from below, above and back to zero
    send_item(FUNC_ADD, pack_item(0, 0, 0, 0, 0, 0, 0, 16'd100));
    send_item(FUNC_ADD, pack_item(0, 0, 0, 0, 0, 0, 0, Q_TOP));
    send_item(FUNC_ADD, pack_item(0, 0, 0, 0, 0, 0, 0, Q_BOTTOM));
    send_item(FUNC_ADD, pack_item(0, 0, 0, 0, 0, 0, 0, 16'd6400));
    // set takes the argument unclamped
    send_item(FUNC_SET, pack_item(0, 0, 0, 0, 0, 0, 0, Q_BOTTOM));
    send_item(FUNC_SAMPLE, pack_item(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(FUNC_SET, pack_item(0, 0, 0, 0, 0, 0, 0, Q_TOP));
    send_item(FUNC_SAMPLE, pack_item(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(FUNC_NOP, pack_item(Q_TOP, Q_BOTTOM, 16'h1234, 0, 0, 0, Q_TOP, Q_BOTTOM));
    send_item(FUNC_SET, pack_item(0, 0, 0, 0, 0, 0, 0, PCT_HALF));
    // yaw accumulator saturates high, then low
    repeat (3) send_item(FUNC_SAMPLE, pack_item(0, 0, 0, 0, 0, 0, Q_TOP, 0));
    repeat (5) send_item(FUNC_SAMPLE, pack_item(0, 0, 0, 0, 0, 0, Q_BOTTOM, 0));
    // widest X and Y errors both ways, commands hit the 16-bit limits
    send_item(FUNC_SAMPLE, pack_item(Q_BOTTOM, Q_TOP, 0, Q_TOP, Q_BOTTOM, 0, 0, 0));
    send_item(FUNC_SAMPLE, pack_item(Q_TOP, Q_BOTTOM, 0, Q_BOTTOM, Q_TOP, 0, Q_TOP, 0));
    send_item(FUNC_SET, pack_item(0, 0, 0, 0, 0, 0, 0, 16'd25000));
    send_item(FUNC_SAMPLE, pack_item(16'd512, 0, 0, 0, 16'd512, 0, 0, 0));

    for (int phase = 0; phase < PHASES; phase++) begin
      // hold input until every result is out before touching the gains
      s_tvalid <= 1'b0;
      wait_drained();
      case (phase)
        0:       begin lin = GAIN_RESET; yaw = GAIN_RESET; end
        1:       begin lin = 16'h0000;   yaw = 16'h0000;   end
        2:       begin lin = 16'hffff;   yaw = 16'hffff;   end
        3:       begin lin = 16'h0001;   yaw = 16'hffff;   end
        4:       begin lin = 16'hffff;   yaw = 16'h0001;   end
        5:       begin lin = 16'($urandom()); yaw = 16'($urandom()); end
        default: begin lin = GAIN_RESET; yaw = 16'($urandom_range(0, 1024)); end
      endcase
      if (phase != 0) begin
        apb_write(ADDR_LIN_GAIN, lin);
        apb_write(ADDR_YAW_GAIN, yaw);
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 32);
        for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
          pick = $urandom_range(0, 19);
          if (pick < 14) func = FUNC_SAMPLE;
          else if (pick < 17) func = FUNC_ADD;
          else if (pick < 19) func = FUNC_SET;
          else func = FUNC_NOP;
          if (func == FUNC_SET && $urandom_range(0, 2) != 0)
            arg = 16'($urandom_range(0, 25600));
          else if (func == FUNC_ADD && $urandom_range(0, 2) != 0)
            arg = 16'($urandom_range(0, 8191) - 4096);
          else arg = rand_q();
          send_item(func, pack_item(rand_q(), rand_q(), rand_q(), rand_q(),
                                    rand_q(), rand_q(), rand_q(), arg));
          sent++;
        end
        if ($urandom_range(0, 2) != 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk);
        end
      end
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/qxmm_pkg.sv
rtl/quad_x_motor_mixer_controller_core.sv
tb/quad_x_motor_mixer_controller_checker.sv
tb/quad_x_motor_mixer_controller_core_tb.sv
